>>> src/cdst_pkg.sv
// Shared types and constants for the countdown delay slot table.
package cdst_pkg;

	// Table size and field widths
	localparam int unsigned SLOTS_DEF = 256;
	localparam int unsigned KIND_W    = 2;
	localparam int unsigned SLOT_W    = 8;
	localparam int unsigned COUNT_W   = 32;

	// Operation codes carried by the kind field
	typedef enum logic [KIND_W-1:0] {
		KIND_POLL  = 2'd0,
		KIND_RESET = 2'd1,
		KIND_TERM  = 2'd2
	} kind_t;

	// Controller states
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;   // capture the input word and read the slot entry
		logic exec;   // update the slot and load the result register
	} cdst_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_blocked;   // result register full and not being taken
	} cdst_stat_t;

endpackage

>>> src/cdst_ctrl.sv
// Controller state machine for the countdown delay slot table.
module cdst_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  cdst_pkg::cdst_stat_t stat,
	output cdst_pkg::cdst_cmd_t  cmd
);
	import cdst_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!stat.out_blocked) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_EXEC: begin
				cmd.exec = !stat.out_blocked;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

>>> src/cdst_dp.sv
// Datapath for the countdown delay slot table: armed bits, count memory, result register.
module cdst_dp #(
	parameter int unsigned SLOTS = cdst_pkg::SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cdst_pkg::cdst_cmd_t           cmd,
	output cdst_pkg::cdst_stat_t          stat,
	input  logic [cdst_pkg::KIND_W-1:0]   kind,
	input  logic [cdst_pkg::SLOT_W-1:0]   slot,
	input  logic [cdst_pkg::COUNT_W-1:0]  cycle_count,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          expired,
	output logic                          start_event,
	output logic                          finish_event
);
	import cdst_pkg::*;

	localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [SLOT_W:0] SLOTS_CMP = (SLOT_W+1)'(SLOTS);

	// Captured input word
	logic [KIND_W-1:0]  kind_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [COUNT_W-1:0] rd_q;

	// Slot state
	logic [SLOTS-1:0]   armed_q;
	logic [COUNT_W-1:0] count_mem [SLOTS];

	// Result register
	logic out_valid_q;
	logic expired_q;
	logic start_q;
	logic finish_q;

	// Update decode
	logic               in_range;
	logic [IDX_W-1:0]   idx;
	logic               armed_rd;
	logic               wr_en;
	logic [COUNT_W-1:0] wr_data;
	logic               armed_wr;
	logic               armed_set;
	logic               res_expired;
	logic               res_start;
	logic               res_finish;

	assign in_range = ({1'b0, slot_q} < SLOTS_CMP);
	assign idx      = slot_q[IDX_W-1:0];
	assign armed_rd = armed_q[idx];

	// Per-operation slot update and result
	always_comb begin
		wr_en       = 1'b0;
		wr_data     = rd_q;
		armed_wr    = 1'b0;
		armed_set   = 1'b0;
		res_expired = 1'b0;
		res_start   = 1'b0;
		res_finish  = 1'b0;
		if (in_range) begin
			unique case (kind_q)
				KIND_POLL: begin
					if (!armed_rd) begin
						armed_wr  = 1'b1;
						armed_set = 1'b1;
						wr_en     = 1'b1;
						wr_data   = (cnt_q != '0) ? (cnt_q - COUNT_W'(1)) : '0;
						res_start = 1'b1;
					end else if (rd_q != '0) begin
						wr_en   = 1'b1;
						wr_data = rd_q - COUNT_W'(1);
					end else begin
						res_expired = 1'b1;
						res_finish  = 1'b1;
					end
				end
				KIND_RESET: begin
					armed_wr  = 1'b1;
					armed_set = 1'b0;
				end
				KIND_TERM: begin
					armed_wr  = 1'b1;
					armed_set = 1'b1;
					wr_en     = 1'b1;
					wr_data   = '0;
				end
				default: begin
					wr_en = 1'b0;
				end
			endcase
		end
	end

	// Input capture and count read
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			slot_q <= slot;
			cnt_q  <= cycle_count;
			rd_q   <= count_mem[slot[IDX_W-1:0]];
		end
	end

	// Count memory write
	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) begin
			count_mem[idx] <= wr_data;
		end
	end

	// Armed bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= '0;
		end else if (cmd.exec && armed_wr) begin
			armed_q[idx] <= armed_set;
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			expired_q <= res_expired;
			start_q   <= res_start;
			finish_q  <= res_finish;
		end
	end

	assign stat.out_blocked = out_valid_q && !out_ready;
	assign out_valid        = out_valid_q;
	assign expired          = expired_q;
	assign start_event      = start_q;
	assign finish_event     = finish_q;

endmodule

>>> src/countdown_delay_slot_table.sv
// Top level of the countdown delay slot table.
//
// A bank of SLOTS delay slots, each an armed bit and a 32-bit countdown.
// Input channel (in_valid/in_ready) carries one word: kind, slot, cycle_count.
// Output channel (out_valid/out_ready) returns one result word per input word:
// expired, start_event, finish_event.
// A poll of an unarmed slot arms it and loads cycle_count - 1 (zero stays
// zero); a poll of an armed slot counts down, or reports finished at zero.
// Reset disarms a slot, terminate arms it with a zero count. Slot numbers
// at or beyond SLOTS are ignored and return an all-zero result.
// On accept, the input word is captured and the slot's count memory entry read;
// the slot is then updated and the result register loaded in the exec state,
// which waits while a previous result is stalled. A new word is not accepted
// until the current one has been through both steps.
// The result register lets a new word be accepted while the previous result
// waits; if the receiver stalls, the next update waits until the result is
// taken, and in_ready stays low meanwhile.
// Reset clears all armed bits at once; the count memory needs no clearing,
// since an entry's value is only used once its armed bit is set.
module countdown_delay_slot_table #(
	parameter int unsigned SLOTS = cdst_pkg::SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [cdst_pkg::KIND_W-1:0]   kind,
	input  logic [cdst_pkg::SLOT_W-1:0]   slot,
	input  logic [cdst_pkg::COUNT_W-1:0]  cycle_count,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          expired,
	output logic                          start_event,
	output logic                          finish_event
);
	import cdst_pkg::*;

	cdst_cmd_t  cmd;
	cdst_stat_t stat;

	cdst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cdst_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.kind         (kind),
		.slot         (slot),
		.cycle_count  (cycle_count),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.expired      (expired),
		.start_event  (start_event),
		.finish_event (finish_event)
	);

endmodule

>>> src/cdst_chk.sv
// Port-level checker for the countdown delay slot table, with its bind.
module cdst_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic expired,
	input logic start_event,
	input logic finish_event
);

	// A stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(expired)
			&& $stable(start_event) && $stable(finish_event))
		else $error("result word changed while stalled");

	// One word in flight: ready drops after an accept
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted back to back");

	// A poll cannot both arm and finish
	a_events_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(start_event && finish_event))
		else $error("start and finish in one result");

	// Expired is reported exactly with the finish event
	a_expired_finish: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (expired == finish_event))
		else $error("expired and finish_event disagree");

endmodule

bind countdown_delay_slot_table cdst_chk u_cdst_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.expired      (expired),
	.start_event  (start_event),
	.finish_event (finish_event)
);

>>> tb/tb_top.sv
// Self-checking testbench for the countdown delay slot table.
`timescale 1ns / 100ps

module tb_top;
	import cdst_pkg::*;

	// Spare kind code that the block must ignore
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int unsigned RANDOM_OPS  = 850;
	localparam int unsigned TAIL_OPS    = 60;     // no idling once this few remain
	localparam int unsigned SETTLE_CYC  = 8;
	localparam int unsigned TIMEOUT_NS  = 5_000_000;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [SLOT_W-1:0]  slot;
		logic [COUNT_W-1:0] cycles;
	} slot_op_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              expired;
		logic              start_event;
		logic              finish_event;
	} slot_flags_t;

	logic                clk;
	logic                arst_n       = 1'b0;
	logic                in_valid     = 1'b0;
	logic                in_ready;
	logic [KIND_W-1:0]   kind         = '0;
	logic [SLOT_W-1:0]   slot         = '0;
	logic [COUNT_W-1:0]  cycle_count  = '0;
	logic                out_valid;
	logic                out_ready    = 1'b0;
	logic                expired;
	logic                start_event;
	logic                finish_event;

	// Stimulus and expectation stores
	slot_op_t    op_q[$];
	slot_flags_t flags_q[$];

	// Shadow copy of the slot table
	bit              armed_bits[SLOTS_DEF];
	logic [COUNT_W-1:0] count_mem[SLOTS_DEF];

	int unsigned mismatch_cnt = 0;
	bit          in_taken     = 1'b0;
	int unsigned in_gap       = 0;
	int unsigned out_gap      = 0;
	int unsigned in_idle_pct  = 0;
	int unsigned out_idle_pct = 0;
	int unsigned sent_cnt     = 0;
	int unsigned cyc_cnt      = 0;
	slot_op_t    drv_op;
	slot_flags_t want;

	countdown_delay_slot_table u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.slot         (slot),
		.cycle_count  (cycle_count),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.expired      (expired),
		.start_event  (start_event),
		.finish_event (finish_event)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Count one mismatch and log it
	task automatic report_err(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		mismatch_cnt++;
	endtask

	task automatic push_op(input logic [KIND_W-1:0] k, input logic [SLOT_W-1:0] s,
			input logic [COUNT_W-1:0] c);
		op_q.push_back('{kind: k, slot: s, cycles: c});
	endtask

	// Apply one word to the shadow table and return the flags it should produce
	function automatic slot_flags_t apply_slot_op(input slot_op_t op);
		slot_flags_t r;
		r = '0;
		r.slot = op.slot;
		if (op.slot < SLOTS_DEF) begin
			case (op.kind)
				KIND_POLL: begin
					if (!armed_bits[op.slot]) begin
						armed_bits[op.slot] = 1'b1;
						count_mem[op.slot] = (op.cycles != '0) ? op.cycles - 1 : '0;
						r.start_event = 1'b1;
					end else if (count_mem[op.slot] != '0) begin
						count_mem[op.slot] = count_mem[op.slot] - 1;
					end else begin
						r.expired = 1'b1;
						r.finish_event = 1'b1;
					end
				end
				KIND_RESET: armed_bits[op.slot] = 1'b0;
				KIND_TERM: begin
					armed_bits[op.slot] = 1'b1;
					count_mem[op.slot] = '0;
				end
				default: ;
			endcase
		end
		return r;
	endfunction

	// Driver: input word and result back-pressure, both changed at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			cyc_cnt <= cyc_cnt + 1;
			if (cyc_cnt % 80 == 0) begin
				case ($urandom_range(0, 2))
					0: out_idle_pct <= 0;
					1: out_idle_pct <= 20;
					default: out_idle_pct <= 45;
				endcase
			end

			if (!in_valid || in_taken) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (op_q.size() > TAIL_OPS && $urandom_range(0, 99) < in_idle_pct) begin
					in_gap <= $urandom_range(0, 10);
					in_valid <= 1'b0;
				end else if (op_q.size() > 0) begin
					drv_op = op_q.pop_front();
					kind <= drv_op.kind;
					slot <= drv_op.slot;
					cycle_count <= drv_op.cycles;
					in_valid <= 1'b1;
					sent_cnt <= sent_cnt + 1;
					if (sent_cnt % 64 == 0) begin
						case ($urandom_range(0, 2))
							0: in_idle_pct <= 0;
							1: in_idle_pct <= 15;
							default: in_idle_pct <= 40;
						endcase
					end
				end else begin
					in_valid <= 1'b0;
				end
			end

			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_ready <= 1'b0;
			end else if (op_q.size() > TAIL_OPS && $urandom_range(0, 99) < out_idle_pct) begin
				out_gap <= $urandom_range(0, 10);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Monitor: predict on input accept, check on result accept
	always @(posedge clk) begin
		if (arst_n) begin
			in_taken = in_valid && in_ready;
			if (in_taken)
				flags_q.push_back(apply_slot_op('{kind: kind, slot: slot, cycles: cycle_count}));
			if (out_valid && out_ready) begin
				if (flags_q.size() == 0) begin
					report_err("result word with nothing expected");
				end else begin
					want = flags_q.pop_front();
					if (expired !== want.expired)
						report_err($sformatf("slot %0d expired %b, want %b",
							want.slot, expired, want.expired));
					if (start_event !== want.start_event)
						report_err($sformatf("slot %0d start_event %b, want %b",
							want.slot, start_event, want.start_event));
					if (finish_event !== want.finish_event)
						report_err($sformatf("slot %0d finish_event %b, want %b",
							want.slot, finish_event, want.finish_event));
				end
			end
		end
	end

	// Stimulus, reset and end of run
	initial begin
		logic [SLOT_W-1:0] hot_slots[6];
		logic [KIND_W-1:0] k;
		logic [SLOT_W-1:0] s;
		logic [COUNT_W-1:0] c;
		int unsigned pick;

		hot_slots = '{8'h00, 8'h01, 8'h5A, 8'hA5, 8'hFE, 8'hFF};

		// Directed: zero-length delay, repeat expiry, disarm, force expired,
		// full-scale count, ignored spare code, ops on unarmed slots
		push_op(KIND_POLL,   8'h00, 32'd0);
		push_op(KIND_POLL,   8'h00, 32'd9);
		push_op(KIND_POLL,   8'h00, 32'd9);
		push_op(KIND_RESET,  8'h00, 32'd0);
		push_op(KIND_POLL,   8'h00, 32'd2);
		push_op(KIND_POLL,   8'h00, 32'd0);
		push_op(KIND_POLL,   8'h00, 32'd0);
		push_op(KIND_TERM,   8'hFF, 32'hFFFF_FFFF);
		push_op(KIND_POLL,   8'hFF, 32'd5);
		push_op(KIND_POLL,   8'h07, 32'hFFFF_FFFF);
		push_op(KIND_POLL,   8'h07, 32'd0);
		push_op(KIND_UNUSED, 8'h07, 32'd0);
		push_op(KIND_TERM,   8'h07, 32'd0);
		push_op(KIND_POLL,   8'h07, 32'd3);
		push_op(KIND_RESET,  8'h0A, 32'd0);
		push_op(KIND_POLL,   8'h0A, 32'd1);
		push_op(KIND_POLL,   8'h0A, 32'hFFFF_FFFF);
		push_op(KIND_RESET,  8'hFF, 32'd0);
		push_op(KIND_POLL,   8'hFF, 32'h8000_0000);
		push_op(KIND_UNUSED, 8'hFF, 32'hFFFF_FFFF);
		push_op(KIND_RESET,  8'h07, 32'd0);
		push_op(KIND_POLL,   8'h07, 32'd0);
		push_op(KIND_TERM,   8'h0A, 32'd0);

		// Random: mostly polls on a few hot slots with short delays so slots
		// run through arm, countdown and expiry; the rest is scattered noise
		repeat (RANDOM_OPS) begin
			pick = $urandom_range(0, 99);
			if (pick < 72)
				k = KIND_POLL;
			else if (pick < 84)
				k = KIND_RESET;
			else if (pick < 94)
				k = KIND_TERM;
			else
				k = KIND_UNUSED;
			s = ($urandom_range(0, 3) == 0) ? SLOT_W'($urandom_range(0, 255))
				: hot_slots[$urandom_range(0, 5)];
			c = ($urandom_range(0, 9) == 0) ? $urandom : COUNT_W'($urandom_range(0, 4));
			push_op(k, s, c);
		end

		repeat (6) @(posedge clk);
		#2 arst_n = 1'b1;

		while (op_q.size() != 0 || in_valid)
			@(negedge clk);
		while (flags_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);

		if (mismatch_cnt == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#(TIMEOUT_NS);
		$display("TIMEOUT @%0t", $time);
		$display("TEST FAILED");
		$finish;
	end

endmodule

>>> sim.f
src/cdst_pkg.sv
src/cdst_ctrl.sv
src/cdst_dp.sv
src/countdown_delay_slot_table.sv
src/cdst_chk.sv
tb/tb_top.sv
